// ----- rtl/triangle_face_normal_top_macros.svh -----
// Assertion helpers for the face normal block.
`ifndef TRIANGLE_FACE_NORMAL_TOP_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TFN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tfn_pkg.sv -----
package tfn_pkg;

  localparam int FIELD_W         = 16;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int EDGE_W          = 18;
  localparam int PROD_W          = 2 * EDGE_W;
  localparam int MAG_W           = 35;
  localparam int POS_W           = 6;
  localparam int NORM_LO         = 29;
  localparam int T_W             = NORM_LO + 1;
  localparam int SQ_W            = 2 * T_W;
  localparam int S_W             = SQ_W + 2;
  localparam int R_W             = S_W / 2;
  localparam int SQRT_REM_W      = R_W + 2;
  localparam int DREM_W          = R_W + 1;
  localparam int LANES           = 3;
  localparam int OUT_W           = 16;
  localparam int IN_TDATA_W      = 9 * FIELD_W;
  localparam int OUT_TDATA_W     = 3 * OUT_W;
  // degenerate flag plus one sign bit per lane
  localparam int DIV_SIDE_W      = LANES + 1;

endpackage

// ----- rtl/tfn_sqrt_cell.sv -----
module tfn_sqrt_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic [tfn_pkg::S_W-1:0]        s_i,
  input  logic [tfn_pkg::SQRT_REM_W-1:0] rem_i,
  input  logic [tfn_pkg::R_W-1:0]        root_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           vld_o,
  output logic [tfn_pkg::S_W-1:0]        s_o,
  output logic [tfn_pkg::SQRT_REM_W-1:0] rem_o,
  output logic [tfn_pkg::R_W-1:0]        root_o,
  output logic [SIDE_W-1:0]              side_o
);
  import tfn_pkg::*;

  logic [SQRT_REM_W-1:0] rem_sh, trial, rem_d;
  logic [R_W-1:0]        root_d;
  logic                  ge;
  logic                  vld_q;
  logic [S_W-1:0]        s_q;
  logic [SQRT_REM_W-1:0] rem_q;
  logic [R_W-1:0]        root_q;
  logic [SIDE_W-1:0]     side_q;

  // one root bit per cell: bring down two radicand bits, try (root*4 + 1)
  always_comb begin
    rem_sh = {rem_i[SQRT_REM_W-3:0], s_i[2*STEP+1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[R_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_i;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign s_o    = s_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

// ----- rtl/tfn_div_cell.sv -----
module tfn_div_cell #(
  parameter int STEP = 0,
  parameter int N_W  = 45,
  parameter int Q_W  = 15
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          vld_i,
  input  logic [tfn_pkg::R_W-1:0]                       r_i,
  input  logic [tfn_pkg::LANES-1:0][N_W-1:0]            num_i,
  input  logic [tfn_pkg::LANES-1:0][tfn_pkg::DREM_W-1:0] rem_i,
  input  logic [tfn_pkg::LANES-1:0][Q_W-1:0]            q_i,
  input  logic [tfn_pkg::DIV_SIDE_W-1:0]                side_i,
  output logic                                          vld_o,
  output logic [tfn_pkg::R_W-1:0]                       r_o,
  output logic [tfn_pkg::LANES-1:0][N_W-1:0]            num_o,
  output logic [tfn_pkg::LANES-1:0][tfn_pkg::DREM_W-1:0] rem_o,
  output logic [tfn_pkg::LANES-1:0][Q_W-1:0]            q_o,
  output logic [tfn_pkg::DIV_SIDE_W-1:0]                side_o
);
  import tfn_pkg::*;

  logic [LANES-1:0][DREM_W-1:0] rem_sh, rem_d;
  logic [LANES-1:0][Q_W-1:0]    q_d;
  logic [DREM_W-1:0]            r_x;
  logic                         vld_q;
  logic [R_W-1:0]               r_q;
  logic [LANES-1:0][N_W-1:0]    num_q;
  logic [LANES-1:0][DREM_W-1:0] rem_q;
  logic [LANES-1:0][Q_W-1:0]    q_q;
  logic [DIV_SIDE_W-1:0]        side_q;

  // restoring division, one quotient bit per lane per cell
  always_comb begin
    r_x = {1'b0, r_i};
    for (int l = 0; l < LANES; l++) begin
      rem_sh[l] = {rem_i[l][DREM_W-2:0], num_i[l][STEP]};
      if (rem_sh[l] >= r_x) begin
        rem_d[l] = rem_sh[l] - r_x;
        q_d[l]   = {q_i[l][Q_W-2:0], 1'b1};
      end else begin
        rem_d[l] = rem_sh[l];
        q_d[l]   = {q_i[l][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= r_i;
      num_q  <= num_i;
      rem_q  <= rem_d;
      q_q    <= q_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign r_o    = r_q;
  assign num_o  = num_q;
  assign rem_o  = rem_q;
  assign q_o    = q_q;
  assign side_o = side_q;

endmodule

// ----- rtl/triangle_face_normal_top.sv -----
// Channel   Dir  Fields (tdata low bit up)                           tuser
// s_axis    in   ax ay az bx by_coord bz cx cy cz, 16 bits each      -
// m_axis    out  norm_x norm_y norm_z, 16 bits each                  degenerate
//
// One triangle per cycle while the output is not stalled; the pipe runs through the front
// stages, the 31-cell square root chain, the numerator register, the divide chain of one
// cell per quotient bit and the output register.
// Reset clears only the valid bits; no clearing pass.
// A stalled output freezes the whole pipe; s_axis_tready_o follows it.
`include "triangle_face_normal_top_macros.svh"

module triangle_face_normal_top #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz
  input  logic [tfn_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // norm_x, norm_y, norm_z
  output logic [tfn_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // degenerate
  output logic                            m_axis_tuser_o
);
  import tfn_pkg::*;

  localparam int Q_W = NORMAL_FRAC_BITS + 1;
  localparam int N_W = T_W + NORMAL_FRAC_BITS + 1;
  localparam int XW  = (Q_W > OUT_W) ? Q_W : OUT_W;
  localparam int SH  = (COORD_WIDTH < FIELD_W) ? (FIELD_W - COORD_WIDTH) : 0;
  localparam int SQ_SIDE_W = LANES * T_W + LANES + 1;
  localparam logic [Q_W-1:0] Q_ONE = {1'b1, {NORMAL_FRAC_BITS{1'b0}}};

  function automatic logic signed [EDGE_W-1:0] read_coord(input logic [FIELD_W-1:0] raw);
    logic signed [FIELD_W-1:0] ext;
    ext = $signed(raw << SH) >>> SH;
    if (COORD_WIDTH > FIELD_W) begin
      return {2'b00, raw};
    end
    return {{(EDGE_W-FIELD_W){ext[FIELD_W-1]}}, ext};
  endfunction

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // front stages
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q, vld8_q, vld9_q;
  logic signed [EDGE_W-1:0] co [9];
  logic signed [EDGE_W-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [PROD_W-1:0] p_q [6];
  logic signed [PROD_W-1:0] n_q [LANES];
  logic [MAG_W-1:0]         mag4_q [LANES], mag5_q [LANES], mag6_q [LANES];
  logic [LANES-1:0]         neg4_q, neg5_q, neg6_q, neg7_q, neg8_q, neg9_q;
  logic [MAG_W-1:0]         m5_q;
  logic [POS_W-1:0]         pos_d, pos6_q;
  logic                     dg6_q, dg7_q, dg8_q, dg9_q;
  logic [T_W-1:0]           t7_q [LANES], t8_q [LANES], t9_q [LANES];
  logic [SQ_W-1:0]          sq8_q [LANES];
  logic [S_W-1:0]           s9_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      co[i] = read_coord(s_axis_tdata_i[i*FIELD_W +: FIELD_W]);
    end
    pos_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m5_q[i]) pos_d = POS_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0; vld2_q <= 1'b0; vld3_q <= 1'b0;
      vld4_q <= 1'b0; vld5_q <= 1'b0; vld6_q <= 1'b0;
      vld7_q <= 1'b0; vld8_q <= 1'b0; vld9_q <= 1'b0;
    end else if (en) begin
      vld1_q <= s_axis_tvalid_i;
      vld2_q <= vld1_q; vld3_q <= vld2_q; vld4_q <= vld3_q;
      vld5_q <= vld4_q; vld6_q <= vld5_q; vld7_q <= vld6_q;
      vld8_q <= vld7_q; vld9_q <= vld8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= co[3] - co[0]; uy_q <= co[4] - co[1]; uz_q <= co[5] - co[2];
      vx_q <= co[6] - co[0]; vy_q <= co[7] - co[1]; vz_q <= co[8] - co[2];
      p_q[0] <= uy_q * vz_q; p_q[1] <= uz_q * vy_q;
      p_q[2] <= uz_q * vx_q; p_q[3] <= ux_q * vz_q;
      p_q[4] <= ux_q * vy_q; p_q[5] <= uy_q * vx_q;
      for (int l = 0; l < LANES; l++) begin
        n_q[l]    <= p_q[2*l] - p_q[2*l+1];
        neg4_q[l] <= n_q[l][PROD_W-1];
        mag4_q[l] <= n_q[l][PROD_W-1] ? MAG_W'(-n_q[l]) : MAG_W'(n_q[l]);
      end
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
      if (mag4_q[0] >= mag4_q[1] && mag4_q[0] >= mag4_q[2]) begin
        m5_q <= mag4_q[0];
      end else if (mag4_q[1] >= mag4_q[2]) begin
        m5_q <= mag4_q[1];
      end else begin
        m5_q <= mag4_q[2];
      end
      mag6_q <= mag5_q;
      neg6_q <= neg5_q;
      pos6_q <= pos_d;
      dg6_q  <= (m5_q == '0);
      // line the largest magnitude up on bit NORM_LO
      for (int l = 0; l < LANES; l++) begin
        t7_q[l] <= T_W'({mag6_q[l], {NORM_LO{1'b0}}} >> pos6_q);
      end
      neg7_q <= neg6_q;
      dg7_q  <= dg6_q;
      for (int l = 0; l < LANES; l++) begin
        sq8_q[l] <= SQ_W'(t7_q[l] * t7_q[l]);
      end
      t8_q   <= t7_q;
      neg8_q <= neg7_q;
      dg8_q  <= dg7_q;
      s9_q   <= S_W'(sq8_q[0]) + S_W'(sq8_q[1]) + S_W'(sq8_q[2]);
      t9_q   <= t8_q;
      neg9_q <= neg8_q;
      dg9_q  <= dg8_q;
    end
  end

  // square root chain
  logic                  sr_vld  [R_W+1];
  logic [S_W-1:0]        sr_s    [R_W+1];
  logic [SQRT_REM_W-1:0] sr_rem  [R_W+1];
  logic [R_W-1:0]        sr_root [R_W+1];
  logic [SQ_SIDE_W-1:0]  sr_side [R_W+1];

  assign sr_vld[0]  = vld9_q;
  assign sr_s[0]    = s9_q;
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_side[0] = {dg9_q, neg9_q, t9_q[2], t9_q[1], t9_q[0]};

  for (genvar k = 0; k < R_W; k++) begin : g_sqrt
    tfn_sqrt_cell #(
      .STEP  (R_W - 1 - k),
      .SIDE_W(SQ_SIDE_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (sr_vld[k]),
      .s_i   (sr_s[k]),
      .rem_i (sr_rem[k]),
      .root_i(sr_root[k]),
      .side_i(sr_side[k]),
      .vld_o (sr_vld[k+1]),
      .s_o   (sr_s[k+1]),
      .rem_o (sr_rem[k+1]),
      .root_o(sr_root[k+1]),
      .side_o(sr_side[k+1])
    );
  end

  // numerator setup: t * 2^F + r/2
  logic [R_W-1:0]               r_fin;
  logic [SQ_SIDE_W-1:0]         side_fin;
  logic [LANES-1:0][N_W-1:0]    num_d, num_q;
  logic [LANES-1:0][DREM_W-1:0] rem0_d, rem0_q;
  logic [R_W-1:0]               rn_q;
  logic [DIV_SIDE_W-1:0]        sn_q;
  logic                         vn_q;

  assign r_fin    = sr_root[R_W];
  assign side_fin = sr_side[R_W];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_d[l]  = {side_fin[l*T_W +: T_W], {NORMAL_FRAC_BITS{1'b0}}, 1'b0} >> 1;
      num_d[l]  = num_d[l] + N_W'(r_fin >> 1);
      rem0_d[l] = DREM_W'(num_d[l][N_W-1:Q_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en) begin
      vn_q <= sr_vld[R_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q  <= num_d;
      rem0_q <= rem0_d;
      rn_q   <= r_fin;
      sn_q   <= side_fin[SQ_SIDE_W-1 -: DIV_SIDE_W];
    end
  end

  // divide chain
  logic                         dv_vld  [Q_W+1];
  logic [R_W-1:0]               dv_r    [Q_W+1];
  logic [LANES-1:0][N_W-1:0]    dv_num  [Q_W+1];
  logic [LANES-1:0][DREM_W-1:0] dv_rem  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]    dv_q    [Q_W+1];
  logic [DIV_SIDE_W-1:0]        dv_side [Q_W+1];

  assign dv_vld[0]  = vn_q;
  assign dv_r[0]    = rn_q;
  assign dv_num[0]  = num_q;
  assign dv_rem[0]  = rem0_q;
  assign dv_q[0]    = '0;
  assign dv_side[0] = sn_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    tfn_div_cell #(
      .STEP(Q_W - 1 - k),
      .N_W (N_W),
      .Q_W (Q_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (dv_vld[k]),
      .r_i   (dv_r[k]),
      .num_i (dv_num[k]),
      .rem_i (dv_rem[k]),
      .q_i   (dv_q[k]),
      .side_i(dv_side[k]),
      .vld_o (dv_vld[k+1]),
      .r_o   (dv_r[k+1]),
      .num_o (dv_num[k+1]),
      .rem_o (dv_rem[k+1]),
      .q_o   (dv_q[k+1]),
      .side_o(dv_side[k+1])
    );
  end

  // sign, clamp and output register
  logic [LANES-1:0][Q_W-1:0]   qc;
  logic [LANES-1:0][XW-1:0]    qs;
  logic [OUT_TDATA_W-1:0]      data_d, data_q;
  logic                        dg_fin;
  logic                        user_q;

  assign dg_fin = dv_side[Q_W][LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qc[l] = (dv_q[Q_W][l] > Q_ONE) ? Q_ONE : dv_q[Q_W][l];
      qs[l] = dv_side[Q_W][l] ? (XW'(0) - XW'(qc[l])) : XW'(qc[l]);
      data_d[l*OUT_W +: OUT_W] = dg_fin ? '0 : qs[l][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      user_q <= dg_fin;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;

  `TFN_ASSERT_IMPL(a_degen_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0, "degenerate triangle with nonzero normal")
  `TFN_ASSERT_IMPL(a_stall_holds_input, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o, "input taken while output stalled")
  `TFN_ASSERT_IMPL(a_root_range, sr_vld[R_W] && !side_fin[SQ_SIDE_W-1], (r_fin >> NORM_LO) != '0, "square root below normalized range")

endmodule

// ----- verif/triangle_face_normal_top_test.sv -----
module triangle_face_normal_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tfn_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic [OUT_W-1:0] nx;
    logic [OUT_W-1:0] ny;
    logic [OUT_W-1:0] nz;
    logic             degen;
  } normal_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  logic [IN_TDATA_W-1:0] tri_queue[$];
  normal_t               normal_queue[$];
  int unsigned           cycle_cnt;
  int unsigned           tri_sent;
  int unsigned           normals_seen;
  int unsigned           degen_seen;
  int unsigned           mismatch_cnt;
  logic                  rx_hold;

  triangle_face_normal_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(logic [IN_TDATA_W-1:0] d);
    longint          c[9];
    longint          n[3];
    longint unsigned t[3];
    longint unsigned m, s, r, q;
    logic            neg[3];
    normal_t         res;
    logic [OUT_W-1:0] lane[3];
    for (int i = 0; i < 9; i++) c[i] = longint'($signed(d[FIELD_W*i +: FIELD_W]));
    // u = b - a, v = c - a
    n[0] = (c[4]-c[1])*(c[8]-c[2]) - (c[5]-c[2])*(c[7]-c[1]);
    n[1] = (c[5]-c[2])*(c[6]-c[0]) - (c[3]-c[0])*(c[8]-c[2]);
    n[2] = (c[3]-c[0])*(c[7]-c[1]) - (c[4]-c[1])*(c[6]-c[0]);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = n[i] < 0;
      t[i]   = neg[i] ? longint'(-n[i]) : n[i];
      if (t[i] > m) m = t[i];
    end
    if (m == 0) begin
      res = '0;
      res.degen = 1'b1;
      return res;
    end
    while (m >= (64'd1 << (NORM_LO + 1))) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) t[i] >>= 1;
    end
    while (m < (64'd1 << NORM_LO)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) t[i] <<= 1;
    end
    s = t[0]*t[0] + t[1]*t[1] + t[2]*t[2];
    r = int_sqrt(s);
    if (r == 0) r = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((t[i] << FRAC) + (r >> 1)) / r;
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      lane[i] = neg[i] ? OUT_W'(-q) : OUT_W'(q);
    end
    res.nx = lane[0];
    res.ny = lane[1];
    res.nz = lane[2];
    res.degen = 1'b0;
    return res;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_tri(int a0, int a1, int a2, int b0, int b1,
                                                     int b2, int c0, int c1, int c2);
    return {16'(c2), 16'(c1), 16'(c0), 16'(b2), 16'(b1), 16'(b0), 16'(a2), 16'(a1), 16'(a0)};
  endfunction

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
    end
  end

  // calm stretch: no idling on either side
  function automatic logic go_idle();
    if (cycle_cnt > 400 && cycle_cnt < 800) return 1'b0;
    return $urandom_range(99) < 15;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic [IN_TDATA_W-1:0] next_tri;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        normal_queue.push_back(face_normal(s_axis_tdata_i));
        tri_sent <= tri_sent + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tri_queue.size() > 0 && !go_idle()) begin
          next_tri = tri_queue.pop_front();
          s_axis_tdata_i  <= next_tri;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : rx_ready
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !rx_hold && !go_idle();
    end
  end

  always @(posedge clk_i) begin : monitor
    normal_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.nx    = m_axis_tdata_o[0 +: OUT_W];
      got.ny    = m_axis_tdata_o[OUT_W +: OUT_W];
      got.nz    = m_axis_tdata_o[2*OUT_W +: OUT_W];
      got.degen = m_axis_tuser_o;
      normals_seen <= normals_seen + 1;
      if (got.degen) degen_seen <= degen_seen + 1;
      if (normal_queue.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected normal transfer %h/%b", m_axis_tdata_o,
                                        m_axis_tuser_o);
      end else begin
        want = normal_queue.pop_front();
        if (got !== want) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("normal mismatch: exp x=%h y=%h z=%h d=%b got x=%h y=%h z=%h d=%b",
                     want.nx, want.ny, want.nz, want.degen,
                     got.nx, got.ny, got.nz, got.degen);
        end
      end
    end
  end

  // long receiver hold-off so the pipe fills and backs up into s_axis
  initial begin
    rx_hold = 1'b0;
    wait (cycle_cnt == 1000);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (250) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int a[3], b[3], c[3];
    int k, kind;
    tri_sent     = 0;
    normals_seen = 0;
    degen_seen   = 0;
    mismatch_cnt = 0;
    rst_ni       = 1'b0;
    // directed: degenerate, extremes, axis-aligned, tiny and huge cross products
    tri_queue.push_back(pack_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_queue.push_back(pack_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
    tri_queue.push_back(pack_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
    tri_queue.push_back(pack_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    tri_queue.push_back(pack_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    tri_queue.push_back(pack_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    tri_queue.push_back(pack_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    tri_queue.push_back(pack_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                 -32768, 32767, -32768));
    tri_queue.push_back(pack_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                 32767, -32768, 32767));
    tri_queue.push_back(pack_tri(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767));
    tri_queue.push_back(pack_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                 32767, -32768, 32767));
    tri_queue.push_back(pack_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                 32767, 32767, 32767));
    tri_queue.push_back(pack_tri(100, 200, 300, 101, 201, 301, 100, 202, 300));
    tri_queue.push_back(pack_tri(0, 0, 0, 3, 4, 0, -4, 3, 0));
    tri_queue.push_back(pack_tri(0, 0, 0, 1, 2, 3, 4, 5, 6));
    tri_queue.push_back(pack_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
    tri_queue.push_back(pack_tri(-1, -1, -1, -1, -1, -1, 0, 0, 0));
    for (int i = 0; i < 1100; i++) begin
      kind = $urandom_range(9);
      for (int j = 0; j < 3; j++) a[j] = rnd16();
      if (kind < 4) begin
        for (int j = 0; j < 3; j++) begin b[j] = rnd16(); c[j] = rnd16(); end
      end else if (kind < 7) begin
        // small triangle near a random vertex
        for (int j = 0; j < 3; j++) begin
          a[j] = $urandom_range(30000) - 15000;
          b[j] = a[j] + $urandom_range(64) - 32;
          c[j] = a[j] + $urandom_range(64) - 32;
        end
      end else if (kind < 9) begin
        // collinear or repeated vertices
        k = $urandom_range(3) - 1;
        for (int j = 0; j < 3; j++) begin
          a[j] = $urandom_range(2000) - 1000;
          b[j] = a[j] + $urandom_range(200) - 100;
          c[j] = a[j] + k * (b[j] - a[j]);
        end
      end else begin
        // nearly axis-aligned, one component dominates
        for (int j = 0; j < 3; j++) begin b[j] = a[j]; c[j] = a[j]; end
        b[0] = 16'(a[0] + $urandom_range(4000));
        b[0] = int'($signed(16'(b[0])));
        c[1] = int'($signed(16'(a[1] + $urandom_range(4000))));
        c[2] = int'($signed(16'(a[2] + $urandom_range(3) - 1)));
      end
      tri_queue.push_back(pack_tri(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (tri_queue.size() == 0);
    @(posedge clk_i);
    while (s_axis_tvalid_i || normal_queue.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("triangles sent: %0d, normals checked: %0d (degenerate %0d), mismatches: %0d",
             tri_sent, normals_seen, degen_seen, mismatch_cnt);
    $display("covered extremes, degenerate and collinear cases, random and small triangles");
    if (mismatch_cnt == 0 && normal_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
